>>> hw/rtl/hex_digits_to_float_bits_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEX_DIGITS_TO_FLOAT_BITS_TOP_MACROS_SVH
`define HEX_DIGITS_TO_FLOAT_BITS_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HDFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hdfb assertion failed");
// next-cycle implication
`define HDFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hdfb assertion failed");
`else
`define HDFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HDFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/hdfb_pkg.sv
// ----------------------------------------------------------------------------
// hdfb_pkg
// Types, constants and helpers for the hex significand packer.
// ----------------------------------------------------------------------------
package hdfb_pkg;

	localparam int SIG_W     = 64;
	localparam int DIG_W     = 5;
	localparam int EXP_W     = 18;
	localparam int EB_W      = 19;
	localparam int NIB_COUNT = SIG_W / 4;

	localparam logic [DIG_W-1:0] MAX_HEX_DIGITS = 5'd16;
	localparam logic [EB_W-1:0]  EXT_BIAS       = 19'h03FFF;
	localparam logic [EB_W-1:0]  DBL_BIAS       = 19'h003FF;
	localparam logic [EB_W-1:0]  EXT_MAX        = 19'h07FFF;
	localparam logic [EB_W-1:0]  DBL_MAX        = 19'h007FF;
	localparam int               DBL_DROP       = 12;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAKE,
		ST_NORM,
		ST_FINISH
	} state_t;

	// ASCII to digit value, same wrap rules as the number parser
	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [31:0] c;
		logic [31:0] v;
		c = {24'd0, ch};
		v = c - 32'd48;
		if (v > 32'd9) begin
			v = c - 32'd65 + 32'd10;
			if (v > 32'd15) begin
				v = c - 32'd97 + 32'd10;
			end
		end
		return v[3:0];
	endfunction

	// leading zero count of a nonzero byte
	function automatic logic [2:0] lz8(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				n = 3'(7 - i);
			end
		end
		return n;
	endfunction

endpackage

>>> hw/rtl/hex_digits_to_float_bits_top.sv
// ----------------------------------------------------------------------------
// hex_digits_to_float_bits_top
// Packs hex digits into a 64-bit significand, normalizes it and emits the
// x87 extended fields and the IEEE double bits.
// ----------------------------------------------------------------------------
// channel  | handshake        | payload
// ---------+------------------+-----------------------------------------------
// digit in | start / busy     | hex_char, start_exponent, first_char, last_char
// result   | done (1 cycle)   | double_bits, ext_significand,
//          |                  | ext_biased_exponent, final_exponent,
//          |                  | zero_significand, range_error
//
// A digit is accepted in ST_IDLE and inserted in ST_TAKE. The last digit of
// a nonzero number adds the normalize loop in ST_NORM, one shift per cycle
// through the shared shifter (a byte while the top byte is clear, then its
// leading zeros), then the pack in ST_FINISH; the result strobes on done. An
// all-zero number skips both. arst_n clears the sequencer and the accumulator.
// The result port cannot be stalled; done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
`include "hex_digits_to_float_bits_top_macros.svh"

module hex_digits_to_float_bits_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [7:0]                        hex_char,
	input  logic signed [15:0]                start_exponent,
	input  logic                              first_char,
	input  logic                              last_char,
	output logic                              done,
	output logic [hdfb_pkg::SIG_W-1:0]        double_bits,
	output logic [hdfb_pkg::SIG_W-1:0]        ext_significand,
	output logic [14:0]                       ext_biased_exponent,
	output logic signed [15:0]                final_exponent,
	output logic                              zero_significand,
	output logic                              range_error
);

	hdfb_pkg::state_t state_q, state_d;

	logic [hdfb_pkg::SIG_W-1:0] acc_q;
	logic [hdfb_pkg::DIG_W-1:0] digits_q;
	logic [hdfb_pkg::EXP_W-1:0] exp_q;

	logic [7:0]  char_q;
	logic [15:0] sexp_q;
	logic        first_q;
	logic        last_q;

	logic                       done_q;
	logic [hdfb_pkg::SIG_W-1:0] dbl_q;
	logic [hdfb_pkg::SIG_W-1:0] sig_q;
	logic [14:0]                ebx_q;
	logic [15:0]                fexp_q;
	logic                       zero_q;
	logic                       rerr_q;

	logic                       accept;
	logic [hdfb_pkg::SIG_W-1:0] acc_take;
	logic [hdfb_pkg::DIG_W-1:0] dig_take;
	logic [hdfb_pkg::EXP_W-1:0] exp_take;
	logic [3:0]                 nib;
	logic                       top_zero;
	logic [2:0]                 lz;
	logic [3:0]                 sh_amt;
	logic [hdfb_pkg::EXP_W-1:0] exp_fin;
	logic [hdfb_pkg::EB_W-1:0]  eb;
	logic [hdfb_pkg::EB_W-1:0]  db;
	logic                       rng_bad;

	assign accept = start && (state_q == hdfb_pkg::ST_IDLE);
	assign busy   = (state_q != hdfb_pkg::ST_IDLE);

	// digit insert: first mark restarts the number, then place the nibble
	always_comb begin
		logic [hdfb_pkg::SIG_W-1:0] a;
		logic [hdfb_pkg::DIG_W-1:0] d;
		logic [hdfb_pkg::EXP_W-1:0] e;
		a   = acc_q;
		d   = digits_q;
		e   = exp_q;
		nib = hdfb_pkg::hex_nibble(char_q);
		if (first_q) begin
			a = '0;
			d = '0;
			e = {{(hdfb_pkg::EXP_W-16){sexp_q[15]}}, sexp_q};
		end
		if (d < hdfb_pkg::MAX_HEX_DIGITS) begin
			for (int i = 0; i < hdfb_pkg::NIB_COUNT; i++) begin
				if (d[3:0] == 4'(hdfb_pkg::NIB_COUNT - 1 - i)) begin
					a[i*4 +: 4] = a[i*4 +: 4] | nib;
				end
			end
			d = d + hdfb_pkg::DIG_W'(1);
			e = e + hdfb_pkg::EXP_W'(4);
		end
		acc_take = a;
		dig_take = d;
		exp_take = e;
	end

	// shared normalize shifter: 8 bits at a time while the top byte is clear
	assign top_zero = (acc_q[63:56] == 8'd0);
	assign lz       = hdfb_pkg::lz8(acc_q[63:56]);
	assign sh_amt   = top_zero ? 4'd8 : {1'b0, lz};

	// exponent biasing
	assign exp_fin = exp_q - hdfb_pkg::EXP_W'(1);
	assign eb = {exp_fin[hdfb_pkg::EXP_W-1], exp_fin} + hdfb_pkg::EXT_BIAS;
	assign db = {exp_fin[hdfb_pkg::EXP_W-1], exp_fin} + hdfb_pkg::DBL_BIAS;
	assign rng_bad = eb[hdfb_pkg::EB_W-1] || (!eb[hdfb_pkg::EB_W-1] && eb > hdfb_pkg::EXT_MAX)
		|| db[hdfb_pkg::EB_W-1] || (!db[hdfb_pkg::EB_W-1] && db > hdfb_pkg::DBL_MAX);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hdfb_pkg::ST_IDLE: begin
				if (start) begin
					state_d = hdfb_pkg::ST_TAKE;
				end
			end
			hdfb_pkg::ST_TAKE: begin
				if (last_q && acc_take != '0) begin
					state_d = hdfb_pkg::ST_NORM;
				end else begin
					state_d = hdfb_pkg::ST_IDLE;
				end
			end
			hdfb_pkg::ST_NORM: begin
				if (!top_zero) begin
					state_d = hdfb_pkg::ST_FINISH;
				end
			end
			hdfb_pkg::ST_FINISH: begin
				state_d = hdfb_pkg::ST_IDLE;
			end
			default: state_d = hdfb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdfb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q  <= hex_char;
			sexp_q  <= start_exponent;
			first_q <= first_char;
			last_q  <= last_char;
		end
	end

	// accumulator and exponent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			digits_q <= '0;
			exp_q    <= '0;
		end else begin
			case (state_q)
				hdfb_pkg::ST_TAKE: begin
					if (last_q && acc_take == '0) begin
						acc_q    <= '0;
						digits_q <= '0;
						exp_q    <= '0;
					end else begin
						acc_q    <= acc_take;
						digits_q <= dig_take;
						exp_q    <= exp_take;
					end
				end
				hdfb_pkg::ST_NORM: begin
					acc_q <= acc_q << sh_amt;
					exp_q <= exp_q - {{(hdfb_pkg::EXP_W-4){1'b0}}, sh_amt};
				end
				hdfb_pkg::ST_FINISH: begin
					acc_q    <= '0;
					digits_q <= '0;
					exp_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == hdfb_pkg::ST_TAKE) && last_q && acc_take == '0)
				|| (state_q == hdfb_pkg::ST_FINISH);
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == hdfb_pkg::ST_TAKE && last_q && acc_take == '0) begin
			dbl_q  <= '0;
			sig_q  <= '0;
			ebx_q  <= '0;
			fexp_q <= '0;
			zero_q <= 1'b1;
			rerr_q <= 1'b0;
		end else if (state_q == hdfb_pkg::ST_FINISH) begin
			dbl_q  <= {1'b0, db[10:0], acc_q[62:hdfb_pkg::DBL_DROP-1]};
			sig_q  <= acc_q;
			ebx_q  <= eb[14:0];
			fexp_q <= exp_fin[15:0];
			zero_q <= 1'b0;
			rerr_q <= rng_bad;
		end
	end

	assign done                = done_q;
	assign double_bits         = dbl_q;
	assign ext_significand     = sig_q;
	assign ext_biased_exponent = ebx_q;
	assign final_exponent      = fexp_q;
	assign zero_significand    = zero_q;
	assign range_error         = rerr_q;

	`HDFB_ASSERT_IMPL(a_zero_clean, clk, arst_n, done && zero_significand, ext_significand == '0 && !range_error)
	`HDFB_ASSERT_IMPL(a_norm_lead, clk, arst_n, done && !zero_significand, ext_significand[63])
	`HDFB_ASSERT_NEXT(a_busy_after, clk, arst_n, start && !busy, busy)
	`HDFB_ASSERT_NEXT(a_single_done, clk, arst_n, done, !done)

endmodule

>>> verif/tb_hex_digits_to_float_bits_top.sv
// ----------------------------------------------------------------------------
// tb_hex_digits_to_float_bits_top
// Feeds hex digit numbers into the packer: a directed set, then random
// numbers with runs of idle cycles. Every result is checked against an
// in-bench model of the significand packing and normalization.
// ----------------------------------------------------------------------------
module tb_hex_digits_to_float_bits_top;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int TARGET_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 24;

	typedef struct {
		logic [7:0]         ch;
		logic signed [15:0] exp0;
		logic               is_first;
		logic               is_last;
		int                 gap;
	} digit_txn_t;

	typedef struct {
		logic [63:0]        dbl;
		logic [63:0]        ext_sig;
		logic [14:0]        ext_be;
		logic signed [15:0] fexp;
		logic               zero;
		logic               rng;
	} float_txn_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic [7:0]                        hex_char = 8'd0;
	logic signed [15:0]                start_exponent = 16'sd0;
	logic                              first_char = 1'b0;
	logic                              last_char = 1'b0;
	logic                              done;
	logic [hdfb_pkg::SIG_W-1:0]        double_bits;
	logic [hdfb_pkg::SIG_W-1:0]        ext_significand;
	logic [14:0]                       ext_biased_exponent;
	logic signed [15:0]                final_exponent;
	logic                              zero_significand;
	logic                              range_error;

	digit_txn_t pending_digits[$];
	float_txn_t expected_floats[$];

	// in-bench copy of the packer state
	logic [63:0]        acc_sig;
	logic [4:0]         acc_count;
	logic signed [17:0] acc_exp;

	int idle_pct;
	int n_items;
	int n_accepted;
	int n_checked;
	int n_zero;
	int n_range;
	int errors;
	int cycles;

	hex_digits_to_float_bits_top u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.hex_char            (hex_char),
		.start_exponent      (start_exponent),
		.first_char          (first_char),
		.last_char           (last_char),
		.done                (done),
		.double_bits         (double_bits),
		.ext_significand     (ext_significand),
		.ext_biased_exponent (ext_biased_exponent),
		.final_exponent      (final_exponent),
		.zero_significand    (zero_significand),
		.range_error         (range_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ASCII to nibble with the parser's unsigned wrap
	function automatic logic [3:0] digit_value(logic [7:0] ch);
		logic [31:0] v;
		v = 32'(ch) - 32'd48;
		if (v > 32'd9) begin
			v = 32'(ch) - 32'd55;
			if (v > 32'd15) begin
				v = 32'(ch) - 32'd87;
			end
		end
		return v[3:0];
	endfunction

	function automatic void clear_packer();
		acc_sig   = '0;
		acc_count = '0;
		acc_exp   = '0;
	endfunction

	// one accepted digit: update the state, queue a float on the last digit
	function automatic void fold_digit(digit_txn_t d);
		float_txn_t  r;
		logic [63:0] sig;
		int          e;
		int          eb;
		int          db;
		if (d.is_first) begin
			acc_sig   = '0;
			acc_count = '0;
			acc_exp   = {{2{d.exp0[15]}}, d.exp0};
		end
		if (acc_count < hdfb_pkg::MAX_HEX_DIGITS) begin
			acc_sig   = acc_sig | (64'(digit_value(d.ch)) << (60 - 4 * int'(acc_count)));
			acc_count = acc_count + 5'd1;
			acc_exp   = acc_exp + 18'sd4;
		end
		if (!d.is_last) begin
			return;
		end
		r = '{default: '0};
		if (acc_sig == '0) begin
			r.zero = 1'b1;
		end else begin
			sig = acc_sig;
			e   = int'(acc_exp);
			while (!sig[63]) begin
				sig = sig << 1;
				e   = e - 1;
			end
			e  = e - 1;
			eb = e + int'(hdfb_pkg::EXT_BIAS);
			db = e + int'(hdfb_pkg::DBL_BIAS);
			r.dbl     = {1'b0, db[10:0], sig[62:11]};
			r.ext_sig = sig;
			r.ext_be  = eb[14:0];
			r.fexp    = e[15:0];
			r.rng     = (eb < 0 || eb > 32767 || db < 0 || db > 2047);
		end
		expected_floats.push_back(r);
		clear_packer();
	endfunction

	function automatic void queue_digit(logic [7:0] ch, logic signed [15:0] exp0,
	                                    logic is_first, logic is_last);
		digit_txn_t d;
		d.ch       = ch;
		d.exp0     = exp0;
		d.is_first = is_first;
		d.is_last  = is_last;
		d.gap      = 0;
		while ($urandom_range(99) < idle_pct && d.gap < 40) begin
			d.gap++;
		end
		pending_digits.push_back(d);
		n_items++;
	endfunction

	function automatic logic [7:0] random_char();
		int k;
		if ($urandom_range(99) < 15) begin
			return 8'($urandom);
		end
		k = $urandom_range(21);
		if (k < 10) begin
			return 8'(48 + k);
		end else if (k < 16) begin
			return 8'(55 + k);
		end
		return 8'(87 + k - 6);
	endfunction

	function automatic logic signed [15:0] random_exponent();
		int e;
		case ($urandom_range(3))
			0: e = $urandom;
			1: e = $urandom_range(2400) - 1200;
			2: begin
				e = 16300 + $urandom_range(180);
				if ($urandom_range(1)) begin
					e = -e;
				end
			end
			default: e = $urandom_range(200) - 100;
		endcase
		return 16'(e);
	endfunction

	// a number of random length; noise drops the first or last mark
	function automatic void queue_random_number();
		int               len;
		int               lead;
		int               sel;
		bit               all_zero;
		bit               with_first;
		bit               with_last;
		logic signed [15:0] e0;
		sel = $urandom_range(9);
		if (sel < 6) begin
			len = $urandom_range(1, 8);
		end else if (sel < 9) begin
			len = $urandom_range(9, 16);
		end else begin
			len = $urandom_range(17, 20);
		end
		all_zero   = ($urandom_range(99) < 10);
		lead       = ($urandom_range(99) < 20) ? $urandom_range(len) : 0;
		with_first = ($urandom_range(99) >= 8);
		with_last  = ($urandom_range(99) >= 8);
		e0 = random_exponent();
		for (int i = 0; i < len; i++) begin
			queue_digit((all_zero || i < lead) ? 8'h30 : random_char(),
			            (i == 0) ? e0 : 16'($urandom),
			            with_first && i == 0, with_last && i == len - 1);
		end
	endfunction

	// driver: feeds the DUT from pending_digits
	logic       gap_loaded;
	int         gap_left;
	digit_txn_t cur;
	always @(posedge clk or negedge arst_n) begin
		logic next_start;
		if (!arst_n) begin
			start          <= 1'b0;
			hex_char       <= 8'd0;
			start_exponent <= 16'sd0;
			first_char     <= 1'b0;
			last_char      <= 1'b0;
			gap_loaded     = 1'b0;
			gap_left       = 0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				fold_digit(cur);
				n_accepted++;
				next_start = 1'b0;
			end
			if (!next_start && pending_digits.size() != 0) begin
				if (!gap_loaded) begin
					gap_left   = pending_digits[0].gap;
					gap_loaded = 1'b1;
				end
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					cur            = pending_digits.pop_front();
					gap_loaded     = 1'b0;
					next_start     = 1'b1;
					hex_char       <= cur.ch;
					start_exponent <= cur.exp0;
					first_char     <= cur.is_first;
					last_char      <= cur.is_last;
				end
			end
			start <= next_start;
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// monitor: one result transaction per done strobe
	always @(posedge clk) begin
		float_txn_t want;
		if (arst_n && done) begin
			if (expected_floats.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual double %h",
				         $time, double_bits);
				errors++;
			end else begin
				want = expected_floats.pop_front();
				check_field("double_bits", want.dbl, double_bits);
				check_field("ext_significand", want.ext_sig, ext_significand);
				check_field("ext_biased_exponent", 64'(want.ext_be), 64'(ext_biased_exponent));
				check_field("final_exponent", 64'(want.fexp), 64'(final_exponent));
				check_field("zero_significand", 64'(want.zero), 64'(zero_significand));
				check_field("range_error", 64'(want.rng), 64'(range_error));
				n_checked++;
				if (want.zero) begin
					n_zero++;
				end
				if (want.rng) begin
					n_range++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycles, expected_floats.size());
			$display("FAIL hex_digits_to_float_bits_top");
			$finish;
		end
	end

	initial begin
		string long_num;
		int    phase;
		clear_packer();
		n_items    = 0;
		n_accepted = 0;
		n_checked  = 0;
		n_zero     = 0;
		n_range    = 0;
		errors     = 0;
		cycles     = 0;
		idle_pct   = 0;

		// single-digit numbers at the exponent extremes and range edges
		queue_digit("0", 16'sd0, 1'b1, 1'b1);
		queue_digit("F", 16'sd32767, 1'b1, 1'b1);
		queue_digit("f", -16'sd32768, 1'b1, 1'b1);
		queue_digit("1", -16'sd1023, 1'b1, 1'b1);
		queue_digit("1", -16'sd1024, 1'b1, 1'b1);
		queue_digit("1", 16'sd1024, 1'b1, 1'b1);
		queue_digit("1", 16'sd1025, 1'b1, 1'b1);
		// no first mark: continues from the cleared state
		queue_digit("9", 16'sd77, 1'b0, 1'b1);
		// non-hex bytes
		queue_digit(8'h00, 16'sd5, 1'b1, 1'b1);
		queue_digit(8'hFF, -16'sd5, 1'b1, 1'b1);
		// 17 characters: the last is past the digit limit and ignored
		long_num = "1b3D5f7@9AcEe0F:G";
		for (int i = 0; i < long_num.len(); i++) begin
			queue_digit(long_num[i], (i == 0) ? 16'sd0 : 16'sd1234,
			            i == 0, i == long_num.len() - 1);
		end

		while (n_items < TARGET_ITEMS) begin
			phase = n_items * 4 / TARGET_ITEMS;
			case (phase)
				1:       idle_pct = 75;
				3:       idle_pct = 33;
				default: idle_pct = 0;
			endcase
			queue_random_number();
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_digits.size() != 0 || start || expected_floats.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d digit transactions accepted, %0d floats checked", n_accepted, n_checked);
		$display("%0d zero significands, %0d range errors, %0d mismatches",
		         n_zero, n_range, errors);
		if (errors == 0 && expected_floats.size() == 0) begin
			$display("PASS hex_digits_to_float_bits_top");
		end else begin
			$display("FAIL hex_digits_to_float_bits_top");
		end
		$finish;
	end

endmodule
